// File: rtl/script_source_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// script_source_tokenizer_macros - assertion helpers
// Property wrappers for the tokenizer; empty bodies when synthesizing.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SST_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");
// next-cycle implication
`define SST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");
`else
`define SST_ASSERT_IMPL(lbl, ante, cons)
`define SST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg - tokenizer shared definitions
// Codes, word layouts and queue sizes used across the tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int DEF_MAX_TOKENS = 1024;
	localparam int DEF_TEXT_MAX   = 32;

	localparam int CQ_DEPTH = 2;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int BURST    = 3;
	localparam int BW       = $clog2(BURST + 1);

	localparam logic [1:0] IK_TOKEN = 2'd0;
	localparam logic [1:0] IK_TEXT  = 2'd1;
	localparam logic [1:0] IK_ERROR = 2'd2;

	localparam logic [4:0] TK_END     = 5'd0;
	localparam logic [4:0] TK_NEWLINE = 5'd1;
	localparam logic [4:0] TK_NUMBER  = 5'd2;
	localparam logic [4:0] TK_STRING  = 5'd3;
	localparam logic [4:0] TK_IDENT   = 5'd4;
	localparam logic [4:0] TK_PLUS    = 5'd5;
	localparam logic [4:0] TK_MINUS   = 5'd6;
	localparam logic [4:0] TK_STAR    = 5'd7;
	localparam logic [4:0] TK_SLASH   = 5'd8;
	localparam logic [4:0] TK_PERCENT = 5'd9;
	localparam logic [4:0] TK_LPAREN  = 5'd10;
	localparam logic [4:0] TK_RPAREN  = 5'd11;
	localparam logic [4:0] TK_ASSIGN  = 5'd12;
	localparam logic [4:0] TK_EQ      = 5'd13;
	localparam logic [4:0] TK_NE      = 5'd14;
	localparam logic [4:0] TK_LT      = 5'd15;
	localparam logic [4:0] TK_LE      = 5'd16;
	localparam logic [4:0] TK_GT      = 5'd17;
	localparam logic [4:0] TK_GE      = 5'd18;

	localparam logic [1:0] ERR_UNKNOWN  = 2'd0;
	localparam logic [1:0] ERR_UNTERM   = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	localparam logic [1:0] REL_ASSIGN = 2'd0;
	localparam logic [1:0] REL_BANG   = 2'd1;
	localparam logic [1:0] REL_LT     = 2'd2;
	localparam logic [1:0] REL_GT     = 2'd3;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_NUMBER  = 3'd1;
	localparam logic [2:0] MODE_IDENT   = 3'd2;
	localparam logic [2:0] MODE_STRING  = 3'd3;
	localparam logic [2:0] MODE_ESCAPE  = 3'd4;
	localparam logic [2:0] MODE_COMMENT = 3'd5;
	localparam logic [2:0] MODE_OPER    = 3'd6;
	localparam logic [2:0] MODE_DRAIN   = 3'd7;

	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_CR  = 8'd13;

	typedef enum logic [3:0] {
		CC_NEWLINE, CC_BLANK, CC_SEMI, CC_HASH, CC_DIGIT, CC_ALPHA,
		CC_QUOTE, CC_REL, CC_SINGLE, CC_BSLASH, CC_OTHER
	} cls_t;

	typedef struct packed {
		logic [7:0] chr;
		logic [7:0] esc;
		cls_t       cls;
		logic [4:0] opk;
		logic       end_only;
		logic       src_end;
	} cword_t;

	typedef struct packed {
		logic [1:0]         item_kind;
		logic [4:0]         token_kind;
		logic signed [31:0] number_value;
		logic [15:0]        line_number;
		logic [7:0]         text_char;
		logic [1:0]         error_code;
		logic               run_last;
	} res_t;

	typedef struct packed {
		logic       held;
		logic [2:0] mode;
	} scan_stat_t;

endpackage

// File: rtl/sst_channels.sv
// ----------------------------------------------------------------------------
// sst_channels - tokenizer stream interfaces
// Source byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sst_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_only;
	logic       source_end;

	modport source (output valid, source_byte, end_only, source_end, input ready);
	modport sink (input valid, source_byte, end_only, source_end, output ready);
endinterface

interface sst_tok_if;
	logic               valid;
	logic               ready;
	logic [1:0]         item_kind;
	logic [4:0]         token_kind;
	logic signed [31:0] number_value;
	logic [15:0]        line_number;
	logic [7:0]         text_char;
	logic [1:0]         error_code;
	logic               run_last;

	modport source (output valid, item_kind, token_kind, number_value, line_number,
		text_char, error_code, run_last, input ready);
	modport sink (input valid, item_kind, token_kind, number_value, line_number,
		text_char, error_code, run_last, output ready);
endinterface

// File: rtl/script_source_tokenizer.sv
// ----------------------------------------------------------------------------
// script_source_tokenizer - streaming script tokenizer
// Turns a source byte stream into tokens, text characters and errors.
//
//   channel  dir  words
//   src      in   source_byte, end_only, source_end
//   tok      out  item_kind, token_kind, number_value, line_number,
//                 text_char, error_code, run_last
//
// One source word per cycle while each word yields at most one result and tok
// is ready; a word yielding several results holds the tok port until all have gone.
// The scanner takes a word only with three free result queue entries, so a
// stalled tok side backs up into the two-entry word queue, then src.ready.
// First result is valid on tok once its word has passed the word queue and the result queue.
// arst_n clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "script_source_tokenizer_macros.svh"

module script_source_tokenizer import sst_pkg::*; #(
	parameter int MAX_TOKENS = DEF_MAX_TOKENS,
	parameter int TEXT_MAX   = DEF_TEXT_MAX
) (
	input  logic      clk,
	input  logic      arst_n,
	sst_src_if.sink   src,
	sst_tok_if.source tok
);

	logic             cq_push;
	cword_t           cq_wdata;
	logic             cq_full;
	logic             cq_valid;
	cword_t           cw;
	logic             cq_pop;
	logic [RQ_AW:0]   rq_free;
	logic [BW-1:0]    push_n;
	res_t [BURST-1:0] push_items;
	scan_stat_t       stat;

	sst_front u_front (
		.src  (src),
		.full (cq_full),
		.push (cq_push),
		.word (cq_wdata)
	);

	sst_cqueue u_cqueue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.full   (cq_full),
		.valid  (cq_valid),
		.rdata  (cw),
		.pop    (cq_pop)
	);

	sst_scan #(
		.MAX_TOKENS (MAX_TOKENS),
		.TEXT_MAX   (TEXT_MAX)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cq_valid   (cq_valid),
		.cw         (cw),
		.cq_pop     (cq_pop),
		.rq_free    (rq_free),
		.push_n     (push_n),
		.push_items (push_items),
		.stat       (stat)
	);

	sst_rqueue u_rqueue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_items (push_items),
		.free       (rq_free),
		.tok        (tok)
	);

	// an error always closes the results of its word
	`SST_ASSERT_IMPL(a_err_last, tok.valid && tok.item_kind == IK_ERROR, tok.run_last)
	// text words belong to a string or identifier
	`SST_ASSERT_IMPL(a_text_kind, tok.valid && tok.item_kind == IK_TEXT,
		tok.token_kind == TK_STRING || tok.token_kind == TK_IDENT)
	// a deferred end word only exists right after a restart
	`SST_ASSERT_IMPL(a_held_idle, stat.held, stat.mode == MODE_IDLE)
	// ending word returns the scanner to idle
	`SST_ASSERT_NEXT(a_end_restart, cq_pop && (cw.end_only || cw.src_end), stat.mode == MODE_IDLE)

endmodule

// File: rtl/sst_front.sv
// ----------------------------------------------------------------------------
// sst_front - byte classifier
// Accepts source words and tags each byte with its character class.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; (
	sst_src_if.sink src,
	input  logic    full,
	output logic    push,
	output cword_t  word
);

	logic [7:0] b;

	assign b         = src.source_byte;
	assign src.ready = !full;
	assign push      = src.valid && !full;

	always_comb begin
		word.chr      = b;
		word.end_only = src.end_only;
		word.src_end  = src.source_end;
		word.esc      = (b == "n") ? CH_NL : (b == "t") ? CH_TAB : b;
		word.opk      = '0;
		word.cls      = CC_OTHER;
		if (b == CH_NL) begin
			word.cls = CC_NEWLINE;
		end else if (b == CH_CR || b == " " || b == CH_TAB) begin
			word.cls = CC_BLANK;
		end else if (b == ";") begin
			word.cls = CC_SEMI;
		end else if (b == "#") begin
			word.cls = CC_HASH;
		end else if (b >= "0" && b <= "9") begin
			word.cls = CC_DIGIT;
		end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
			word.cls = CC_ALPHA;
		end else if (b == 8'h22) begin
			word.cls = CC_QUOTE;
		end else if (b == 8'h5C) begin
			word.cls = CC_BSLASH;
		end else if (b == "=") begin
			word.cls = CC_REL;
			word.opk = {3'd0, REL_ASSIGN};
		end else if (b == "!") begin
			word.cls = CC_REL;
			word.opk = {3'd0, REL_BANG};
		end else if (b == "<") begin
			word.cls = CC_REL;
			word.opk = {3'd0, REL_LT};
		end else if (b == ">") begin
			word.cls = CC_REL;
			word.opk = {3'd0, REL_GT};
		end else if (b == "+") begin
			word.cls = CC_SINGLE;
			word.opk = TK_PLUS;
		end else if (b == "-") begin
			word.cls = CC_SINGLE;
			word.opk = TK_MINUS;
		end else if (b == "*") begin
			word.cls = CC_SINGLE;
			word.opk = TK_STAR;
		end else if (b == "/") begin
			word.cls = CC_SINGLE;
			word.opk = TK_SLASH;
		end else if (b == "%") begin
			word.cls = CC_SINGLE;
			word.opk = TK_PERCENT;
		end else if (b == "(") begin
			word.cls = CC_SINGLE;
			word.opk = TK_LPAREN;
		end else if (b == ")") begin
			word.cls = CC_SINGLE;
			word.opk = TK_RPAREN;
		end
	end

endmodule

// File: rtl/sst_cqueue.sv
// ----------------------------------------------------------------------------
// sst_cqueue - classified word queue
// Short queue between the classifier and the scanner.
// ----------------------------------------------------------------------------
module sst_cqueue import sst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cword_t wdata,
	output logic   full,
	output logic   valid,
	output cword_t rdata,
	input  logic   pop
);

	localparam int AW = $clog2(CQ_DEPTH);

	cword_t        mem_q [CQ_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;

	assign full  = (count_q == (AW+1)'(CQ_DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: rtl/sst_scan.sv
// ----------------------------------------------------------------------------
// sst_scan - token scanner
// Runs the scan state machine on one classified word per cycle while the result
// queue has three free entries, and hands up to three results to it.
// ----------------------------------------------------------------------------
module sst_scan import sst_pkg::*; #(
	parameter int MAX_TOKENS = DEF_MAX_TOKENS,
	parameter int TEXT_MAX   = DEF_TEXT_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cq_valid,
	input  cword_t               cw,
	output logic                 cq_pop,
	input  logic [RQ_AW:0]       rq_free,
	output logic [BW-1:0]        push_n,
	output res_t [BURST-1:0]     push_items,
	output scan_stat_t           stat
);

	localparam int TCW = $clog2(MAX_TOKENS);
	localparam int TLW = $clog2(TEXT_MAX);
	localparam logic [TCW-1:0] TC_LIM = TCW'(MAX_TOKENS - 1);
	localparam logic [TLW-1:0] TL_LIM = TLW'(TEXT_MAX - 1);
	localparam int NSLOT = 5;

	logic [2:0]     mode_q;
	logic [1:0]     pend_q;
	logic [31:0]    acc_q;
	logic [TLW-1:0] tlen_q;
	logic [15:0]    cline_q;
	logic [15:0]    sline_q;
	logic [TCW-1:0] tcnt_q;
	logic           held_q;
	res_t           held_item_q;

	logic [2:0]       m;
	logic [1:0]       p;
	logic [31:0]      a;
	logic [TLW-1:0]   tl;
	logic [15:0]      cl;
	logic [15:0]      sl;
	logic [TCW-1:0]   tc;
	res_t             slot [NSLOT];
	logic [NSLOT-1:0] sv;
	res_t [BURST-1:0] outs;
	res_t             held_n;
	logic             held_vn;
	logic [BW-1:0]    n;

	function automatic res_t mk(logic [1:0] ik, logic [4:0] tk, logic [31:0] num,
		logic [15:0] ln, logic [7:0] ch, logic [1:0] ec);
		res_t r;
		r.item_kind    = ik;
		r.token_kind   = tk;
		r.number_value = $signed(num);
		r.line_number  = ln;
		r.text_char    = ch;
		r.error_code   = ec;
		r.run_last     = 1'b0;
		return r;
	endfunction

	function automatic logic [15:0] line_step(logic [15:0] l);
		return (l == 16'hFFFF) ? l : l + 16'd1;
	endfunction

	function automatic logic [4:0] rel_one(logic [1:0] op);
		logic [4:0] k;
		unique case (op)
			REL_LT:  k = TK_LT;
			REL_GT:  k = TK_GT;
			default: k = TK_ASSIGN;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rel_two(logic [1:0] op);
		logic [4:0] k;
		unique case (op)
			REL_ASSIGN: k = TK_EQ;
			REL_BANG:   k = TK_NE;
			REL_LT:     k = TK_LE;
			REL_GT:     k = TK_GE;
		endcase
		return k;
	endfunction

	assign cq_pop = cq_valid && (rq_free >= (RQ_AW+1)'(BURST));
	assign push_n = cq_pop ? n : '0;
	assign push_items = outs;
	assign stat.held  = held_q;
	assign stat.mode  = mode_q;

	always_comb begin
		logic          start;
		logic          needs;
		logic [31:0]   d;
		logic [2:0]    rk;
		m  = mode_q;
		p  = pend_q;
		a  = acc_q;
		tl = tlen_q;
		cl = cline_q;
		sl = sline_q;
		tc = tcnt_q;
		d  = {28'd0, cw.chr[3:0]};
		start = 1'b0;
		needs = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			slot[i] = '0;
		end
		sv      = '0;
		slot[0] = held_item_q;
		sv[0]   = held_q;

		// slot 1: result of continuing the current token
		if (!cw.end_only) begin
			unique case (m)
				MODE_NUMBER: begin
					if (cw.cls == CC_DIGIT) begin
						a = {a[28:0], 3'd0} + {a[30:0], 1'b0} + d;
					end else begin
						slot[1] = mk(IK_TOKEN, TK_NUMBER, a, sl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						m       = MODE_IDLE;
						start   = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (cw.cls == CC_ALPHA || cw.cls == CC_DIGIT) begin
						if (tl < TL_LIM) begin
							slot[1] = mk(IK_TEXT, TK_IDENT, 32'd0, sl, cw.chr, ERR_UNKNOWN);
							sv[1]   = 1'b1;
							tl      = tl + TLW'(1);
						end
					end else begin
						slot[1] = mk(IK_TOKEN, TK_IDENT, 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						m       = MODE_IDLE;
						start   = 1'b1;
					end
				end
				MODE_OPER: begin
					m = MODE_IDLE;
					if (cw.cls == CC_REL && cw.opk[1:0] == REL_ASSIGN) begin
						slot[1] = mk(IK_TOKEN, rel_two(p), 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
					end else if (p == REL_BANG) begin
						// lone bang
						slot[1] = mk(IK_ERROR, TK_END, 32'd0, cl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						m       = MODE_DRAIN;
					end else begin
						slot[1] = mk(IK_TOKEN, rel_one(p), 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						start   = 1'b1;
					end
					p = REL_ASSIGN;
				end
				MODE_STRING: begin
					if (cw.cls == CC_QUOTE) begin
						slot[1] = mk(IK_TOKEN, TK_STRING, 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						m       = MODE_IDLE;
					end else if (cw.cls == CC_BSLASH) begin
						m = MODE_ESCAPE;
					end else begin
						if (tl < TL_LIM) begin
							slot[1] = mk(IK_TEXT, TK_STRING, 32'd0, sl, cw.chr, ERR_UNKNOWN);
							sv[1]   = 1'b1;
							tl      = tl + TLW'(1);
						end
						if (cw.cls == CC_NEWLINE) begin
							cl = line_step(cl);
						end
					end
				end
				MODE_ESCAPE: begin
					m = MODE_STRING;
					if (tl < TL_LIM) begin
						slot[1] = mk(IK_TEXT, TK_STRING, 32'd0, sl, cw.esc, ERR_UNKNOWN);
						sv[1]   = 1'b1;
						tl      = tl + TLW'(1);
					end
					if (cw.esc == CH_NL) begin
						cl = line_step(cl);
					end
				end
				MODE_COMMENT: begin
					if (cw.cls == CC_NEWLINE) begin
						m     = MODE_IDLE;
						start = 1'b1;
					end
				end
				MODE_DRAIN: begin
				end
				MODE_IDLE: begin
					start = 1'b1;
				end
			endcase
		end

		// slot 2: byte opens a new token
		if (start) begin
			needs = (cw.cls == CC_NEWLINE) || (cw.cls == CC_SEMI) || (cw.cls == CC_DIGIT) ||
				(cw.cls == CC_ALPHA) || (cw.cls == CC_QUOTE) || (cw.cls == CC_REL) ||
				(cw.cls == CC_SINGLE);
			if (needs && tc == TC_LIM) begin
				slot[2] = mk(IK_ERROR, TK_END, 32'd0, cl, 8'd0, ERR_OVERFLOW);
				sv[2]   = 1'b1;
				m       = MODE_DRAIN;
			end else begin
				if (needs) begin
					tc = tc + TCW'(1);
					sl = cl;
				end
				unique case (cw.cls)
					CC_NEWLINE: begin
						slot[2] = mk(IK_TOKEN, TK_NEWLINE, 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[2]   = 1'b1;
						cl      = line_step(cl);
					end
					CC_BLANK: begin
					end
					CC_SEMI: begin
						slot[2] = mk(IK_TOKEN, TK_NEWLINE, 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[2]   = 1'b1;
					end
					CC_HASH: begin
						m = MODE_COMMENT;
					end
					CC_DIGIT: begin
						m = MODE_NUMBER;
						a = d;
					end
					CC_ALPHA: begin
						m       = MODE_IDENT;
						slot[2] = mk(IK_TEXT, TK_IDENT, 32'd0, sl, cw.chr, ERR_UNKNOWN);
						sv[2]   = 1'b1;
						tl      = TLW'(1);
					end
					CC_QUOTE: begin
						m  = MODE_STRING;
						tl = '0;
					end
					CC_REL: begin
						m = MODE_OPER;
						p = cw.opk[1:0];
					end
					CC_SINGLE: begin
						slot[2] = mk(IK_TOKEN, cw.opk, 32'd0, sl, 8'd0, ERR_UNKNOWN);
						sv[2]   = 1'b1;
					end
					default: begin
						slot[2] = mk(IK_ERROR, TK_END, 32'd0, cl, 8'd0, ERR_UNKNOWN);
						sv[2]   = 1'b1;
						m       = MODE_DRAIN;
					end
				endcase
			end
		end

		// slots 3 and 4: end of source flushes or faults the open token, then the end token unless draining
		if (cw.end_only || cw.src_end) begin
			unique case (m)
				MODE_NUMBER: begin
					slot[3] = mk(IK_TOKEN, TK_NUMBER, a, sl, 8'd0, ERR_UNKNOWN);
					sv[3]   = 1'b1;
				end
				MODE_IDENT: begin
					slot[3] = mk(IK_TOKEN, TK_IDENT, 32'd0, sl, 8'd0, ERR_UNKNOWN);
					sv[3]   = 1'b1;
				end
				MODE_OPER: begin
					if (p == REL_BANG) begin
						slot[3] = mk(IK_ERROR, TK_END, 32'd0, cl, 8'd0, ERR_UNKNOWN);
						m       = MODE_DRAIN;
					end else begin
						slot[3] = mk(IK_TOKEN, rel_one(p), 32'd0, sl, 8'd0, ERR_UNKNOWN);
					end
					sv[3] = 1'b1;
				end
				MODE_STRING, MODE_ESCAPE: begin
					slot[3] = mk(IK_ERROR, TK_END, 32'd0, cl, 8'd0, ERR_UNTERM);
					sv[3]   = 1'b1;
					m       = MODE_DRAIN;
				end
				default: begin
				end
			endcase
			if (m != MODE_DRAIN) begin
				slot[4] = mk(IK_TOKEN, TK_END, 32'd0, cl, 8'd0, ERR_UNKNOWN);
				sv[4]   = 1'b1;
			end
			m  = MODE_IDLE;
			p  = REL_ASSIGN;
			a  = '0;
			tl = '0;
			cl = 16'd1;
			sl = 16'd1;
			tc = '0;
		end

		// pack valid slots in order, a fourth one waits for the next word
		outs    = '0;
		held_n  = '0;
		held_vn = 1'b0;
		rk      = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (sv[i]) begin
				if (rk < 3'(BURST)) begin
					outs[rk[1:0]] = slot[i];
				end else if (rk == 3'(BURST)) begin
					held_n  = slot[i];
					held_vn = 1'b1;
				end
				rk = rk + 3'd1;
			end
		end
		n = (rk > 3'(BURST)) ? BW'(BURST) : rk[BW-1:0];
		for (int k = 0; k < BURST; k++) begin
			outs[k].run_last = (n == BW'(k + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			held_item_q <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= REL_ASSIGN;
			acc_q   <= '0;
			tlen_q  <= '0;
			cline_q <= 16'd1;
			sline_q <= 16'd1;
			tcnt_q  <= '0;
			held_q  <= 1'b0;
		end else if (cq_pop) begin
			mode_q  <= m;
			pend_q  <= p;
			acc_q   <= a;
			tlen_q  <= tl;
			cline_q <= cl;
			sline_q <= sl;
			tcnt_q  <= tc;
			held_q  <= held_vn;
		end
	end

endmodule

// File: rtl/sst_rqueue.sv
// ----------------------------------------------------------------------------
// sst_rqueue - result queue
// Takes up to three results per cycle and drives them out one per cycle while tok.ready is high.
// ----------------------------------------------------------------------------
module sst_rqueue import sst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [BW-1:0]    push_n,
	input  res_t [BURST-1:0] push_items,
	output logic [RQ_AW:0]   free,
	sst_tok_if.source        tok
);

	res_t             mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wptr_q;
	logic [RQ_AW-1:0] rptr_q;
	logic [RQ_AW:0]   count_q;
	logic             pop;
	res_t             head;

	assign pop  = tok.valid && tok.ready;
	assign free = (RQ_AW+1)'(RQ_DEPTH) - count_q;
	assign head = mem_q[rptr_q];

	assign tok.valid        = (count_q != '0);
	assign tok.item_kind    = head.item_kind;
	assign tok.token_kind   = head.token_kind;
	assign tok.number_value = head.number_value;
	assign tok.line_number  = head.line_number;
	assign tok.text_char    = head.text_char;
	assign tok.error_code   = head.error_code;
	assign tok.run_last     = head.run_last;

	always_ff @(posedge clk) begin
		for (int k = 0; k < BURST; k++) begin
			if (BW'(k) < push_n) begin
				mem_q[wptr_q + RQ_AW'(k)] <= push_items[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + RQ_AW'(push_n);
			if (pop) begin
				rptr_q <= rptr_q + RQ_AW'(1);
			end
			count_q <= count_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
		end
	end

endmodule

// File: dv/script_source_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_source_tokenizer_tb - self-checking bench for the source tokenizer
// Streams directed and random script sources into the byte channel, predicts
// every token, text character and error word in a behavioral scanner, and
// compares them in order against the result channel under random backpressure.
// ----------------------------------------------------------------------------
module script_source_tokenizer_tb;
	import sst_pkg::*;

	localparam int MAX_TOK     = DEF_MAX_TOKENS;
	localparam int TXT_MAX     = DEF_TEXT_MAX;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct {
		logic [7:0] chr;
		logic       end_only;
		logic       source_end;
	} src_word_t;

	logic clk;
	logic arst_n;

	sst_src_if src_ch ();
	sst_tok_if tok_ch ();

	script_source_tokenizer #(
		.MAX_TOKENS(MAX_TOK),
		.TEXT_MAX  (TXT_MAX)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src_ch),
		.tok   (tok_ch)
	);

	src_word_t word_q[$];
	res_t      expected_tokens[$];
	res_t      step_res[$];

	// scanner shadow state
	logic [2:0]  scan_st;
	logic [1:0]  rel_op;
	logic [31:0] num_acc;
	int          txt_len;
	logic [15:0] cur_line;
	logic [15:0] start_line;
	int          tok_cnt;
	bit          err_seen;
	bit          hold_valid;
	res_t        hold_res;

	int        fail_cnt = 0;
	int        cycle_cnt = 0;
	int        burst_left;
	int        gap_left;
	src_word_t taken;
	src_word_t nxt;
	logic [7:0] stall_pat;
	int         stall_left;

	string op_text [14] = '{"+", "-", "*", "/", "%", "(", ")",
		"=", "==", "!=", "<", "<=", ">", ">="};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// token prediction
	// ------------------------------------------------------------------
	function automatic void add_res(logic [1:0] kind, logic [4:0] tk, logic [31:0] num,
		logic [15:0] line, logic [7:0] ch, logic [1:0] code);
		res_t r;
		r.item_kind    = kind;
		r.token_kind   = tk;
		r.number_value = num;
		r.line_number  = line;
		r.text_char    = ch;
		r.error_code   = code;
		r.run_last     = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void tok_out(logic [4:0] tk, logic [31:0] num);
		add_res(IK_TOKEN, tk, num, start_line, '0, '0);
	endfunction

	function automatic void advance_line();
		if (cur_line != 16'hFFFF)
			cur_line++;
	endfunction

	function automatic void flag_err(logic [1:0] code);
		add_res(IK_ERROR, '0, '0, cur_line, '0, code);
		scan_st  = MODE_DRAIN;
		err_seen = 1'b1;
	endfunction

	// tokens are counted when they begin
	function automatic bit open_token();
		if (tok_cnt >= MAX_TOK - 1) begin
			flag_err(ERR_OVERFLOW);
			return 1'b0;
		end
		tok_cnt++;
		start_line = cur_line;
		return 1'b1;
	endfunction

	function automatic void text_out(logic [7:0] ch);
		if (txt_len < TXT_MAX - 1) begin
			add_res(IK_TEXT, (scan_st == MODE_IDENT) ? TK_IDENT : TK_STRING, '0,
				start_line, ch, '0);
			txt_len++;
		end
	endfunction

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [4:0] rel_kind(logic [1:0] rel, bit with_eq);
		case (rel)
			REL_ASSIGN: return with_eq ? TK_EQ : TK_ASSIGN;
			REL_BANG:   return TK_NE;
			REL_LT:     return with_eq ? TK_LE : TK_LT;
			default:    return with_eq ? TK_GE : TK_GT;
		endcase
	endfunction

	function automatic logic [4:0] single_kind(logic [7:0] c);
		case (c)
			"+":     return TK_PLUS;
			"-":     return TK_MINUS;
			"*":     return TK_STAR;
			"/":     return TK_SLASH;
			"%":     return TK_PERCENT;
			"(":     return TK_LPAREN;
			")":     return TK_RPAREN;
			default: return TK_END;
		endcase
	endfunction

	function automatic void clear_source();
		scan_st    = MODE_IDLE;
		rel_op     = REL_ASSIGN;
		num_acc    = '0;
		txt_len    = 0;
		cur_line   = 16'd1;
		start_line = 16'd1;
		tok_cnt    = 0;
		err_seen   = 1'b0;
	endfunction

	function automatic void scan_start(logic [7:0] c);
		logic [4:0] k;
		if (c == CH_CR || c == " " || c == CH_TAB)
			return;
		if (c == CH_NL) begin
			if (open_token()) begin
				tok_out(TK_NEWLINE, '0);
				advance_line();
			end
		end else if (c == ";") begin
			if (open_token())
				tok_out(TK_NEWLINE, '0);
		end else if (c == "#") begin
			scan_st = MODE_COMMENT;
		end else if (digit_char(c)) begin
			if (open_token()) begin
				scan_st = MODE_NUMBER;
				num_acc = 32'(c - "0");
			end
		end else if (alpha_char(c)) begin
			if (open_token()) begin
				scan_st = MODE_IDENT;
				txt_len = 0;
				text_out(c);
			end
		end else if (c == "\"") begin
			if (open_token()) begin
				scan_st = MODE_STRING;
				txt_len = 0;
			end
		end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
			if (open_token()) begin
				scan_st = MODE_OPER;
				rel_op  = (c == "=") ? REL_ASSIGN : (c == "!") ? REL_BANG :
					(c == "<") ? REL_LT : REL_GT;
			end
		end else begin
			k = single_kind(c);
			if (k != TK_END) begin
				if (open_token())
					tok_out(k, '0);
			end else begin
				flag_err(ERR_UNKNOWN);
			end
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c);
		logic [7:0] ch;
		case (scan_st)
			MODE_NUMBER: begin
				if (digit_char(c)) begin
					num_acc = num_acc * 32'd10 + 32'(c - "0");
					return;
				end
				tok_out(TK_NUMBER, num_acc);
				scan_st = MODE_IDLE;
			end
			MODE_IDENT: begin
				if (alpha_char(c) || digit_char(c)) begin
					text_out(c);
					return;
				end
				tok_out(TK_IDENT, '0);
				scan_st = MODE_IDLE;
			end
			MODE_OPER: begin
				scan_st = MODE_IDLE;
				if (c == "=") begin
					tok_out(rel_kind(rel_op, 1'b1), '0);
					rel_op = REL_ASSIGN;
					return;
				end
				if (rel_op == REL_BANG) begin
					rel_op = REL_ASSIGN;
					flag_err(ERR_UNKNOWN);
					return;
				end
				tok_out(rel_kind(rel_op, 1'b0), '0);
				rel_op = REL_ASSIGN;
			end
			MODE_STRING: begin
				if (c == "\"") begin
					tok_out(TK_STRING, '0);
					scan_st = MODE_IDLE;
				end else if (c == "\\") begin
					scan_st = MODE_ESCAPE;
				end else begin
					text_out(c);
					if (c == CH_NL)
						advance_line();
				end
				return;
			end
			MODE_ESCAPE: begin
				ch = (c == "n") ? CH_NL : (c == "t") ? CH_TAB : c;
				scan_st = MODE_STRING;
				text_out(ch);
				if (ch == CH_NL)
					advance_line();
				return;
			end
			MODE_COMMENT: begin
				if (c != CH_NL)
					return;
				scan_st = MODE_IDLE;
			end
			MODE_DRAIN: return;
			default: scan_st = MODE_IDLE;
		endcase
		scan_start(c);
	endfunction

	function automatic void scan_end();
		case (scan_st)
			MODE_NUMBER: tok_out(TK_NUMBER, num_acc);
			MODE_IDENT:  tok_out(TK_IDENT, '0);
			MODE_OPER: begin
				if (rel_op == REL_BANG)
					flag_err(ERR_UNKNOWN);
				else
					tok_out(rel_kind(rel_op, 1'b0), '0);
			end
			MODE_STRING, MODE_ESCAPE: flag_err(ERR_UNTERM);
			default: ;
		endcase
		if (!err_seen)
			add_res(IK_TOKEN, TK_END, '0, cur_line, '0, '0);
		clear_source();
	endfunction

	function automatic void predict_tokens(src_word_t w);
		int   n;
		res_t r;
		step_res.delete();
		if (hold_valid) begin
			step_res.push_back(hold_res);
			hold_valid = 1'b0;
		end
		if (!w.end_only)
			scan_byte(w.chr);
		if (w.end_only || w.source_end)
			scan_end();
		// an end token that would overflow the burst waits for the next word
		if (step_res.size() > BURST) begin
			hold_res   = step_res[BURST];
			hold_valid = 1'b1;
		end
		n = (step_res.size() > BURST) ? BURST : step_res.size();
		for (int k = 0; k < n; k++) begin
			r          = step_res[k];
			r.run_last = (k == n - 1);
			expected_tokens.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		fail_cnt++;
		$display("tokenizer mismatch, cycle %0d: %s", cycle_cnt, what);
	endtask

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_token_word();
		res_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch($sformatf("unexpected result word, item_kind %0d",
				tok_ch.item_kind));
			return;
		end
		want = expected_tokens.pop_front();
		cmp_field("item_kind", tok_ch.item_kind, want.item_kind);
		cmp_field("token_kind", tok_ch.token_kind, want.token_kind);
		cmp_field("number_value", tok_ch.number_value, want.number_value);
		cmp_field("line_number", tok_ch.line_number, want.line_number);
		cmp_field("text_char", tok_ch.text_char, want.text_char);
		cmp_field("error_code", tok_ch.error_code, want.error_code);
		cmp_field("run_last", tok_ch.run_last, want.run_last);
	endtask

	// ------------------------------------------------------------------
	// source generation
	// ------------------------------------------------------------------
	task automatic push_word(logic [7:0] c, bit eo, bit se);
		src_word_t w;
		w.chr        = c;
		w.end_only   = eo;
		w.source_end = se;
		word_q.push_back(w);
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], 1'b0, 1'b0);
	endtask

	task automatic set_last_end();
		word_q[word_q.size() - 1].source_end = 1'b1;
	endtask

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == "\"" || c == "\\");
		return c;
	endfunction

	// mostly short, now and then past the text limit
	function automatic int text_len();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(TXT_MAX - 2, TXT_MAX + 6)
			: $urandom_range(1, 6);
	endfunction

	task automatic gen_number();
		int n;
		n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 4);
		repeat (n)
			push_word(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0);
	endtask

	task automatic gen_ident();
		int n;
		n = text_len();
		push_word(pick_alpha(), 1'b0, 1'b0);
		repeat (n - 1)
			push_word(($urandom_range(0, 4) == 0) ? 8'("0" + $urandom_range(0, 9)) :
				pick_alpha(), 1'b0, 1'b0);
	endtask

	task automatic gen_string();
		int n;
		n = text_len();
		push_word("\"", 1'b0, 1'b0);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: begin
					push_word("\\", 1'b0, 1'b0);
					case ($urandom_range(0, 4))
						0:       push_word("n", 1'b0, 1'b0);
						1:       push_word("t", 1'b0, 1'b0);
						2:       push_word("\"", 1'b0, 1'b0);
						3:       push_word("\\", 1'b0, 1'b0);
						default: push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					endcase
				end
				1:       push_word(CH_NL, 1'b0, 1'b0);
				default: push_word(pick_plain(), 1'b0, 1'b0);
			endcase
		end
		push_word("\"", 1'b0, 1'b0);
	endtask

	task automatic gen_separator();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: push_word(CH_NL, 1'b0, 1'b0);
			1: push_word(";", 1'b0, 1'b0);
			2: push_word(CH_TAB, 1'b0, 1'b0);
			3: push_word(CH_CR, 1'b0, 1'b0);
			default: begin
				push_word("#", 1'b0, 1'b0);
				repeat ($urandom_range(0, 6)) begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == CH_NL);
					push_word(c, 1'b0, 1'b0);
				end
				push_word(CH_NL, 1'b0, 1'b0);
			end
		endcase
	endtask

	task automatic gen_noise();
		case ($urandom_range(0, 3))
			0:       push_word("!", 1'b0, 1'b0);
			1:       push_word("@", 1'b0, 1'b0);
			2:       push_word("$", 1'b0, 1'b0);
			default: push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		endcase
	endtask

	task automatic close_source(bit has_bytes);
		if (!has_bytes || $urandom_range(0, 2) == 0)
			push_word(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
		else
			set_last_end();
	endtask

	task automatic gen_sources(int n_words);
		int made;
		int first;
		int r;
		made = 0;
		while (made < n_words) begin
			first = word_q.size();
			repeat ($urandom_range(1, 8)) begin
				r = $urandom_range(0, 23);
				if (r < 4)
					gen_number();
				else if (r < 8)
					gen_ident();
				else if (r < 11)
					gen_string();
				else if (r < 17)
					push_str(op_text[$urandom_range(0, 13)]);
				else if (r < 22)
					gen_separator();
				else
					gen_noise();
				if ($urandom_range(0, 1))
					push_word(" ", 1'b0, 1'b0);
			end
			// string left open at the end of the source
			if ($urandom_range(0, 11) == 0) begin
				push_word("\"", 1'b0, 1'b0);
				repeat ($urandom_range(0, 3))
					push_word(pick_plain(), 1'b0, 1'b0);
				if ($urandom_range(0, 1))
					push_word("\\", 1'b0, 1'b0);
			end
			close_source(word_q.size() > first);
			made += word_q.size() - first;
		end
	endtask

	// ------------------------------------------------------------------
	// byte driver, feeds the scanner in bursts
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch.valid       <= 1'b0;
			src_ch.source_byte <= '0;
			src_ch.end_only    <= 1'b0;
			src_ch.source_end  <= 1'b0;
			burst_left = $urandom_range(1, 16);
			gap_left   = 0;
			clear_source();
			hold_valid = 1'b0;
		end else begin
			if (src_ch.valid && src_ch.ready) begin
				taken.chr        = src_ch.source_byte;
				taken.end_only   = src_ch.end_only;
				taken.source_end = src_ch.source_end;
				predict_tokens(taken);
			end
			if (!src_ch.valid || src_ch.ready) begin
				if (gap_left > 0 || word_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					src_ch.valid <= 1'b0;
				end else begin
					nxt = word_q.pop_front();
					src_ch.valid       <= 1'b1;
					src_ch.source_byte <= nxt.chr;
					src_ch.end_only    <= nxt.end_only;
					src_ch.source_end  <= nxt.source_end;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor with its own stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			stall_pat  = 8'hFF;
			stall_left = 0;
		end else begin
			if (tok_ch.valid && tok_ch.ready)
				check_token_word();
			if (stall_left == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pat = 8'hFF;
					1:       stall_pat = 8'($urandom);
					2:       stall_pat = 8'($urandom | $urandom);
					default: stall_pat = 8'($urandom & $urandom);
				endcase
				// at least one ready bit in every rotation of the pattern
				stall_pat[0] = 1'b1;
				stall_left   = 8 * $urandom_range(2, 8);
			end
			tok_ch.ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[7:1]};
			stall_left--;
		end
	end

	// ------------------------------------------------------------------
	// sources and end of run
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;

		push_str("x=1");
		set_last_end();
		push_str("<=>");
		set_last_end();
		// lone bang closed by the source end
		push_str("!=!");
		set_last_end();
		// trailing backslash inside a string
		push_str("\"a\\");
		set_last_end();
		push_str("#c\n;");
		set_last_end();
		push_str("(%)");
		set_last_end();
		// unknown byte, then an end word that must stay silent
		push_word("@", 1'b0, 1'b0);
		push_word(8'hFF, 1'b1, 1'b0);
		push_word(8'h00, 1'b1, 1'b0);
		// four results on one word: end token spills into the next word
		push_str("9a");
		set_last_end();
		push_word(CH_TAB, 1'b0, 1'b1);

		gen_sources(85);
		gen_sources(85);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || src_ch.valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
